>>> hw/rtl/slcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slcp_pkg
// Shared types and constants of the sync/length/checksum packet parser.
// ----------------------------------------------------------------------------
package slcp_pkg;

  localparam int unsigned BYTE_W = 8;

  // Stream framing
  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;
  localparam logic [BYTE_W-1:0] LEN_ESC   = 8'd170;

  // Row walk
  localparam logic [BYTE_W-1:0] EXT_BYTE      = 8'h55;
  localparam logic [BYTE_W-1:0] LONG_CODE_MIN = 8'h80;

  // Raw word pairing
  localparam logic [BYTE_W-1:0] RAW_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] RAW_HI   = 8'h80;
  localparam logic [BYTE_W-1:0] RAW_LO   = 8'h40;
  localparam logic [BYTE_W-1:0] RAW_CODE = 8'd128;
  localparam logic [BYTE_W-1:0] RAW_LEN  = 8'd2;

  // Request kinds
  localparam logic REQ_STREAM = 1'b0;
  localparam logic REQ_PULL   = 1'b1;

  typedef enum logic [2:0] {
    ST_TAKEN    = 3'd0,
    ST_GOOD     = 3'd1,
    ST_CSUM_BAD = 3'd2,
    ST_LEN_BIG  = 3'd3,
    ST_LEN_ESC  = 3'd4,
    ST_RAW      = 3'd5,
    ST_ROW      = 3'd6,
    ST_NONE     = 3'd7
  } status_e;

  typedef struct packed {
    status_e           status;
    logic [BYTE_W-1:0] ext_level;
    logic [BYTE_W-1:0] row_code;
    logic [BYTE_W-1:0] row_length;
    logic [BYTE_W-1:0] byte_index;
    logic [BYTE_W-1:0] value_byte;
    logic              last_in_row;
    logic              last_in_packet;
    logic [15:0]       raw_word;
  } res_t;

  // Packet events from the stream parser to the row walker
  typedef struct packed {
    logic clr_ready;
    logic pkt_good;
  } ev_t;

endpackage
`default_nettype wire

>>> hw/rtl/slcp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slcp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hw/rtl/slcp_stream.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slcp_stream
// Stream byte parser: sync/length/checksum framing, payload store writes and
// raw word pairing. One stream byte per cycle.
// ----------------------------------------------------------------------------
module slcp_stream #(
  parameter int unsigned PAYLOAD_DEPTH = 256,
  localparam int unsigned AW = $clog2(PAYLOAD_DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         acc_i,
  input  wire logic [slcp_pkg::BYTE_W-1:0]  byte_i,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_wdata_i,
  output logic                              mem_we_o,
  output logic      [AW-1:0]                mem_waddr_o,
  output logic      [slcp_pkg::BYTE_W-1:0]  mem_wdata_o,
  output logic      [slcp_pkg::BYTE_W-1:0]  dlen_o,
  output slcp_pkg::ev_t                     ev_o,
  output logic                              done_o,
  output slcp_pkg::res_t                    res_o
);

  localparam logic [2:0] PH_SYNC1   = 3'd0;
  localparam logic [2:0] PH_SYNC2   = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;
  localparam logic [2:0] PH_HIGH    = 3'd5;
  localparam logic [2:0] PH_LOW     = 3'd6;

  localparam int unsigned CW = slcp_pkg::BYTE_W;

  logic          mode_q, mode_d;
  logic [2:0]    phase_q, phase_d;
  logic [CW-1:0] prev_q, prev_d;
  logic [CW-1:0] dlen_q, dlen_d;
  logic [CW-1:0] rcnt_q, rcnt_d;
  logic [CW-1:0] sum_q, sum_d;
  logic [CW-1:0] rcnt_inc;
  logic          in_range;

  assign rcnt_inc = rcnt_q + 8'd1;
  assign in_range = {1'b0, rcnt_q} < (CW+1)'(PAYLOAD_DEPTH);

  always_comb begin
    mode_d   = mode_q;
    phase_d  = phase_q;
    prev_d   = prev_q;
    dlen_d   = dlen_q;
    rcnt_d   = rcnt_q;
    sum_d    = sum_q;
    mem_we_o = 1'b0;
    ev_o     = '0;
    res_o    = '0;
    res_o.status = slcp_pkg::ST_TAKEN;

    if (acc_i) begin
      prev_d = byte_i;
      case (phase_q)
        PH_SYNC1: begin
          if (byte_i == slcp_pkg::SYNC_BYTE) begin
            phase_d = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          phase_d = (byte_i == slcp_pkg::SYNC_BYTE) ? PH_LEN : PH_SYNC1;
        end
        PH_LEN: begin
          dlen_d = byte_i;
          if (byte_i > slcp_pkg::LEN_ESC) begin
            phase_d      = PH_SYNC1;
            res_o.status = slcp_pkg::ST_LEN_BIG;
          end else if (byte_i == slcp_pkg::LEN_ESC) begin
            // stay: next byte is another length
            res_o.status = slcp_pkg::ST_LEN_ESC;
          end else begin
            rcnt_d         = '0;
            sum_d          = '0;
            ev_o.clr_ready = 1'b1;
            phase_d        = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          mem_we_o = in_range;
          rcnt_d   = rcnt_inc;
          sum_d    = sum_q + byte_i;
          if (rcnt_inc >= dlen_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_d = PH_SYNC1;
          if (byte_i != ~sum_q) begin
            res_o.status = slcp_pkg::ST_CSUM_BAD;
          end else begin
            res_o.status  = slcp_pkg::ST_GOOD;
            ev_o.pkt_good = 1'b1;
          end
        end
        PH_HIGH: begin
          if ((byte_i & slcp_pkg::RAW_MASK) == slcp_pkg::RAW_HI) begin
            phase_d = PH_LOW;
          end
        end
        PH_LOW: begin
          if ((byte_i & slcp_pkg::RAW_MASK) == slcp_pkg::RAW_LO) begin
            res_o.status     = slcp_pkg::ST_RAW;
            res_o.row_code   = slcp_pkg::RAW_CODE;
            res_o.row_length = slcp_pkg::RAW_LEN;
            res_o.raw_word   = {prev_q, byte_i};
          end
          phase_d = PH_HIGH;
        end
        default: begin
          phase_d = mode_q ? PH_HIGH : PH_SYNC1;
        end
      endcase
    end

    // mode write restarts parsing in the start phase of the new mode
    if (cfg_we_i) begin
      mode_d  = cfg_wdata_i;
      phase_d = cfg_wdata_i ? PH_HIGH : PH_SYNC1;
      prev_d  = '0;
      dlen_d  = '0;
      rcnt_d  = '0;
      sum_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      phase_q <= PH_SYNC1;
      prev_q  <= '0;
      dlen_q  <= '0;
      rcnt_q  <= '0;
      sum_q   <= '0;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      prev_q  <= prev_d;
      dlen_q  <= dlen_d;
      rcnt_q  <= rcnt_d;
      sum_q   <= sum_d;
    end
  end

  assign mem_waddr_o = AW'(rcnt_q);
  assign mem_wdata_o = byte_i;
  assign dlen_o      = dlen_q;
  assign done_o      = acc_i;

endmodule
`default_nettype wire

>>> hw/rtl/slcp_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slcp_walker
// Row walker: serves pulls by stepping through the stored payload one RAM
// read at a time, tracking extended level, row code, length and offset.
// ----------------------------------------------------------------------------
module slcp_walker #(
  parameter int unsigned PAYLOAD_DEPTH = 256,
  localparam int unsigned AW = $clog2(PAYLOAD_DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         restart_i,
  input  wire slcp_pkg::ev_t                ev_i,
  input  wire logic [slcp_pkg::BYTE_W-1:0]  lim_i,
  output logic      [AW-1:0]                raddr_o,
  input  wire logic [slcp_pkg::BYTE_W-1:0]  rdata_i,
  output logic                              busy_o,
  output logic                              done_o,
  output slcp_pkg::res_t                    res_o
);

  localparam int unsigned CW = slcp_pkg::BYTE_W;

  localparam logic [3:0] W_IDLE  = 4'd0;
  localparam logic [3:0] W_START = 4'd1;
  localparam logic [3:0] W_SCAN  = 4'd2;
  localparam logic [3:0] W_CODE  = 4'd3;
  localparam logic [3:0] W_LRD   = 4'd4;
  localparam logic [3:0] W_LDAT  = 4'd5;
  localparam logic [3:0] W_ROW   = 4'd6;
  localparam logic [3:0] W_VRD   = 4'd7;
  localparam logic [3:0] W_VDAT  = 4'd8;

  logic [3:0]    state_q, state_d;
  logic          look_q, look_d;    // lookahead for end of packet
  logic          ready_q, ready_d;
  logic          inr_q;

  // working walker
  logic [CW-1:0] wpos_q, wpos_d, wlev_q, wlev_d, wcode_q, wcode_d;
  logic [CW-1:0] wlen_q, wlen_d, woff_q, woff_d;
  // committed walker
  logic [CW-1:0] cpos_q, cpos_d, clev_q, clev_d, ccode_q, ccode_d;
  logic [CW-1:0] clen_q, clen_d, coff_q, coff_d;
  // value byte held across the lookahead
  logic [CW-1:0] idx_q, idx_d, val_q, val_d;

  logic [CW-1:0] rd;
  logic [CW-1:0] pos_inc, off_inc, rem, skip;
  logic          fail, found, last_row;

  assign rd      = inr_q ? rdata_i : '0;
  assign pos_inc = wpos_q + 8'd1;
  assign off_inc = woff_q + 8'd1;
  assign rem     = lim_i - wpos_q;
  assign skip    = (wlen_q < rem) ? wlen_q : rem;
  assign last_row = !((off_inc < wlen_q) && (pos_inc < lim_i));

  always_comb begin
    state_d = state_q;
    look_d  = look_q;
    ready_d = ready_q;
    wpos_d  = wpos_q;
    wlev_d  = wlev_q;
    wcode_d = wcode_q;
    wlen_d  = wlen_q;
    woff_d  = woff_q;
    cpos_d  = cpos_q;
    clev_d  = clev_q;
    ccode_d = ccode_q;
    clen_d  = clen_q;
    coff_d  = coff_q;
    idx_d   = idx_q;
    val_d   = val_q;
    fail    = 1'b0;
    found   = 1'b0;
    done_o  = 1'b0;
    res_o   = '0;
    res_o.status = slcp_pkg::ST_NONE;

    case (state_q)
      W_IDLE: begin
        if (start_i) begin
          wpos_d  = cpos_q;
          wlev_d  = clev_q;
          wcode_d = ccode_q;
          wlen_d  = clen_q;
          woff_d  = coff_q;
          look_d  = 1'b0;
          state_d = W_START;
        end
      end
      W_START: begin
        if (!ready_q) begin
          done_o  = 1'b1;
          state_d = W_IDLE;
        end else if ((woff_q < wlen_q) && (wpos_q < lim_i)) begin
          state_d = W_VRD;
        end else begin
          state_d = W_SCAN;
        end
      end
      W_SCAN: begin
        if (wpos_q >= lim_i) begin
          fail = 1'b1;
        end else begin
          state_d = W_CODE;
        end
      end
      W_CODE: begin
        wpos_d = pos_inc;
        if (rd == slcp_pkg::EXT_BYTE) begin
          if (wlev_q != '1) begin
            wlev_d = wlev_q + 8'd1;
          end
          state_d = W_SCAN;
        end else begin
          wcode_d = rd;
          woff_d  = '0;
          if (rd >= slcp_pkg::LONG_CODE_MIN) begin
            if (pos_inc >= lim_i) begin
              wlen_d = '0;
              fail   = 1'b1;
            end else begin
              state_d = W_LRD;
            end
          end else begin
            wlen_d  = 8'd1;
            state_d = W_ROW;
          end
        end
      end
      W_LRD: begin
        state_d = W_LDAT;
      end
      W_LDAT: begin
        wlen_d  = rd;
        wpos_d  = pos_inc;
        state_d = W_ROW;
      end
      W_ROW: begin
        if ((wlen_q != '0) && (wpos_q < lim_i)) begin
          found = 1'b1;
        end else begin
          // empty or clipped row: jump over its value bytes
          wpos_d  = wpos_q + skip;
          state_d = W_SCAN;
        end
      end
      W_VRD: begin
        state_d = W_VDAT;
      end
      W_VDAT: begin
        wpos_d  = pos_inc;
        woff_d  = off_inc;
        cpos_d  = pos_inc;
        clev_d  = wlev_q;
        ccode_d = wcode_q;
        clen_d  = wlen_q;
        coff_d  = off_inc;
        idx_d   = woff_q;
        val_d   = rd;
        if (!last_row) begin
          done_o           = 1'b1;
          res_o.status     = slcp_pkg::ST_ROW;
          res_o.ext_level  = wlev_q;
          res_o.row_code   = wcode_q;
          res_o.row_length = wlen_q;
          res_o.byte_index = woff_q;
          res_o.value_byte = rd;
          state_d          = W_IDLE;
        end else begin
          look_d  = 1'b1;
          state_d = W_SCAN;
        end
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase

    if (found) begin
      if (!look_q) begin
        state_d = W_VRD;
      end else begin
        done_o           = 1'b1;
        res_o.status     = slcp_pkg::ST_ROW;
        res_o.ext_level  = clev_q;
        res_o.row_code   = ccode_q;
        res_o.row_length = clen_q;
        res_o.byte_index = idx_q;
        res_o.value_byte = val_q;
        res_o.last_in_row = 1'b1;
        state_d          = W_IDLE;
      end
    end

    if (fail) begin
      ready_d = 1'b0;
      done_o  = 1'b1;
      state_d = W_IDLE;
      if (look_q) begin
        res_o.status         = slcp_pkg::ST_ROW;
        res_o.ext_level      = clev_q;
        res_o.row_code       = ccode_q;
        res_o.row_length     = clen_q;
        res_o.byte_index     = idx_q;
        res_o.value_byte     = val_q;
        res_o.last_in_row    = 1'b1;
        res_o.last_in_packet = 1'b1;
      end
    end

    if (restart_i || ev_i.pkt_good) begin
      ready_d = ev_i.pkt_good && !restart_i;
      cpos_d  = '0;
      clev_d  = '0;
      ccode_d = '0;
      clen_d  = '0;
      coff_d  = '0;
      state_d = W_IDLE;
    end else if (ev_i.clr_ready) begin
      ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      look_q  <= 1'b0;
      ready_q <= 1'b0;
      cpos_q  <= '0;
      clev_q  <= '0;
      ccode_q <= '0;
      clen_q  <= '0;
      coff_q  <= '0;
    end else begin
      state_q <= state_d;
      look_q  <= look_d;
      ready_q <= ready_d;
      cpos_q  <= cpos_d;
      clev_q  <= clev_d;
      ccode_q <= ccode_d;
      clen_q  <= clen_d;
      coff_q  <= coff_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wpos_q  <= wpos_d;
    wlev_q  <= wlev_d;
    wcode_q <= wcode_d;
    wlen_q  <= wlen_d;
    woff_q  <= woff_d;
    idx_q   <= idx_d;
    val_q   <= val_d;
    // positions past the store read as zero
    inr_q   <= {1'b0, wpos_q} < (CW+1)'(PAYLOAD_DEPTH);
  end

  assign raddr_o = AW'(wpos_q);
  assign busy_o  = (state_q != W_IDLE);

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == W_IDLE)
    else $error("pull started while walker busy");

  a_val_in_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == W_VDAT |-> (woff_q < wlen_q) && (wpos_q < lim_i))
    else $error("value byte read outside its row");

endmodule
`default_nettype wire

>>> hw/rtl/slcp_outbuf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slcp_outbuf
// Result output register with one skid entry behind it.
// ----------------------------------------------------------------------------
module slcp_outbuf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire slcp_pkg::res_t  res_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output slcp_pkg::res_t       res_o,
  output logic                 full_o
);

  logic           out_v_q, out_v_d;
  logic           skid_v_q, skid_v_d;
  slcp_pkg::res_t out_q, out_d;
  slcp_pkg::res_t skid_q, skid_d;
  logic           free;

  assign free = !out_v_q || !out_stall_i;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (free) begin
      if (skid_v_q) begin
        // advance skid entry, keep order
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = valid_i;
        if (valid_i) begin
          skid_d = res_i;
        end
      end else begin
        out_v_d = valid_i;
        if (valid_i) begin
          out_d = res_i;
        end
      end
    end else if (valid_i) begin
      skid_d   = res_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign res_o       = out_q;
  assign full_o      = skid_v_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held with empty output register");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> !(skid_v_q && out_v_q && out_stall_i))
    else $error("result produced with no room to hold it");

endmodule
`default_nettype wire

>>> hw/rtl/sync_length_checksum_packet_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_checksum_packet_parser_core
// Parser for a sync/length/checksum byte stream with pull-based row readout.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): req_type_i 0 carries a stream byte
// in data_byte_i, req_type_i 1 pulls the next value byte of a good packet.
// Output channel (out_valid_o / out_stall_i): exactly one result transaction
// per input transaction, in order.
// A stream byte's result is registered in the output register or, behind a
// held result, in the skid entry, and the next transaction may enter without
// waiting for it. A pull walks the payload RAM through its single read port,
// stepping over 0x55 bytes and over rows with short and long codes, with a
// lookahead at the end of each row that finds last_in_packet; in_stall_o
// stays high while the walk runs.
// The output register has one skid entry behind it, so a transaction is
// taken while one result waits; with both full, in_stall_o rises until the
// receiver drops out_stall_i.
// cfg_we_i writes parser_mode and restarts parsing in that mode.
// Reset selects packet mode, waits for the first sync and marks no packet
// ready; the payload RAM is not cleared.
// ----------------------------------------------------------------------------
module sync_length_checksum_packet_parser_core #(
  parameter int unsigned PAYLOAD_DEPTH = 256
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       req_type_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      status_o,
  output logic [7:0]      ext_level_o,
  output logic [7:0]      row_code_o,
  output logic [7:0]      row_length_o,
  output logic [7:0]      byte_index_o,
  output logic [7:0]      value_byte_o,
  output logic            last_in_row_o,
  output logic            last_in_packet_o,
  output logic [15:0]     raw_word_o
);

  localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);

  logic                          acc, s_acc, w_start;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [slcp_pkg::BYTE_W-1:0]   mem_wdata, mem_rdata, dlen;
  slcp_pkg::ev_t                 ev;
  logic                          s_done, w_done, w_busy, prod, ob_full;
  slcp_pkg::res_t                s_res, w_res, res, out_res;

  assign in_stall_o = w_busy || ob_full;
  assign acc        = in_valid_i && !in_stall_o;
  assign s_acc      = acc && (req_type_i == slcp_pkg::REQ_STREAM);
  assign w_start    = acc && (req_type_i == slcp_pkg::REQ_PULL);

  slcp_stream #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_stream (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (s_acc),
    .byte_i      (data_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .dlen_o      (dlen),
    .ev_o        (ev),
    .done_o      (s_done),
    .res_o       (s_res)
  );

  slcp_ram #(
    .WIDTH(slcp_pkg::BYTE_W),
    .DEPTH(PAYLOAD_DEPTH)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  slcp_walker #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (w_start),
    .restart_i (cfg_we_i),
    .ev_i      (ev),
    .lim_i     (dlen),
    .raddr_o   (mem_raddr),
    .rdata_i   (mem_rdata),
    .busy_o    (w_busy),
    .done_o    (w_done),
    .res_o     (w_res)
  );

  assign prod = s_done || w_done;
  assign res  = w_done ? w_res : s_res;

  slcp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (prod),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res),
    .full_o      (ob_full)
  );

  assign status_o         = out_res.status;
  assign ext_level_o      = out_res.ext_level;
  assign row_code_o       = out_res.row_code;
  assign row_length_o     = out_res.row_length;
  assign byte_index_o     = out_res.byte_index;
  assign value_byte_o     = out_res.value_byte;
  assign last_in_row_o    = out_res.last_in_row;
  assign last_in_packet_o = out_res.last_in_packet;
  assign raw_word_o       = out_res.raw_word;

  a_stream_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> prod && !w_done)
    else $error("stream byte accepted without a result in the same cycle");

endmodule
`default_nettype wire

>>> tb/sync_length_checksum_packet_parser_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_length_checksum_packet_parser_core_test
// Drives stream bytes and pulls through the parser and checks each result
// transaction against a cycle-free model of the parser kept in the bench.
// A short directed run covers framing errors, the length escape, zero and
// clipped payloads, then random phases run in packet and raw word modes
// with bursty input and a receiver that stalls on its own pattern.
// ----------------------------------------------------------------------------
module sync_length_checksum_packet_parser_core_test;
  import slcp_pkg::*;

  localparam int ITEM_TARGET   = 1750;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 40;
  localparam int LIVE          = 0;  // model copy advanced on accepted transactions
  localparam int PLAN          = 1;  // model copy advanced while building stimulus

  typedef enum logic [2:0] {
    WAIT_SYNC1,
    WAIT_SYNC2,
    WAIT_LEN,
    GET_PAYLOAD,
    GET_CHECK,
    RAW_HIGH,
    RAW_LOW
  } parse_phase_e;

  typedef enum logic {
    JOB_XFER,
    JOB_MODE
  } job_op_e;

  typedef struct packed {
    job_op_e    op;
    logic       req;
    logic [7:0] data;
  } job_t;

  typedef struct packed {
    logic [8:0] pos;
    logic [8:0] off;
    logic [7:0] level;
    logic [7:0] code;
    logic [7:0] len;
  } walk_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       req_type = REQ_STREAM;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] status;
  logic [7:0] ext_level;
  logic [7:0] row_code;
  logic [7:0] row_length;
  logic [7:0] byte_index;
  logic [7:0] value_byte;
  logic       last_in_row;
  logic       last_in_packet;
  logic [15:0] raw_word;

  // Parser model state, one copy per index
  logic         ps_mode  [2];
  parse_phase_e ps_phase [2];
  logic [7:0]   ps_prev  [2];
  logic [7:0]   ps_dlen  [2];
  logic [7:0]   ps_rcnt  [2];
  logic [7:0]   ps_sum   [2];
  logic [7:0]   ps_store [2][256];
  logic         ps_ready [2];
  logic [7:0]   ps_rpos  [2];
  logic [7:0]   ps_level [2];
  logic [7:0]   ps_code  [2];
  logic [7:0]   ps_rlen  [2];
  logic [7:0]   ps_roff  [2];

  job_t stream_jobs_q[$];
  res_t parser_results_q[$];
  int   mismatch_count = 0;
  int   counted = 0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   settle_cnt = 0;
  int   stall_mode = 0;
  int   stall_left = 0;

  sync_length_checksum_packet_parser_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .req_type_i       (req_type),
    .data_byte_i      (data_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .ext_level_o      (ext_level),
    .row_code_o       (row_code),
    .row_length_o     (row_length),
    .byte_index_o     (byte_index),
    .value_byte_o     (value_byte),
    .last_in_row_o    (last_in_row),
    .last_in_packet_o (last_in_packet),
    .raw_word_o       (raw_word)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic void parser_restart(input int k);
    if (ps_mode[k]) begin
      ps_phase[k] = RAW_HIGH;
    end else begin
      ps_phase[k] = WAIT_SYNC1;
    end
    ps_prev[k]  = 8'h00;
    ps_dlen[k]  = 8'h00;
    ps_rcnt[k]  = 8'h00;
    ps_sum[k]   = 8'h00;
    ps_ready[k] = 1'b0;
    ps_rpos[k]  = 8'h00;
    ps_level[k] = 8'h00;
    ps_code[k]  = 8'h00;
    ps_rlen[k]  = 8'h00;
    ps_roff[k]  = 8'h00;
  endfunction

  function automatic void parser_set_mode(input int k, input logic m);
    ps_mode[k] = m;
    parser_restart(k);
  endfunction

  function automatic void parser_reset(input int k);
    for (int i = 0; i < 256; i++) ps_store[k][i] = 8'h00;
    parser_set_mode(k, 1'b0);
  endfunction

  // Advance to the next row that still has a value byte inside the payload.
  function automatic bit seek_row(input int k, inout walk_t w);
    logic [8:0] lim;
    lim = {1'b0, ps_dlen[k]};
    while (w.pos < lim) begin
      while (w.pos < lim && ps_store[k][w.pos] == EXT_BYTE) begin
        if (w.level != 8'hFF) w.level = w.level + 8'd1;
        w.pos = w.pos + 9'd1;
      end
      if (w.pos >= lim) return 1'b0;
      w.code = ps_store[k][w.pos];
      w.pos  = w.pos + 9'd1;
      w.off  = 9'd0;
      if (w.code >= LONG_CODE_MIN) begin
        if (w.pos >= lim) begin
          w.len = 8'd0;
          return 1'b0;
        end
        w.len = ps_store[k][w.pos];
        w.pos = w.pos + 9'd1;
      end else begin
        w.len = 8'd1;
      end
      if (w.len != 8'd0 && w.pos < lim) return 1'b1;
      // skip the empty or clipped row
      if ({1'b0, w.len} < lim - w.pos) begin
        w.pos = w.pos + {1'b0, w.len};
      end else begin
        w.pos = lim;
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t parse_transaction(input int k, input logic req,
                                             input logic [7:0] b);
    res_t       r;
    walk_t      w;
    walk_t      t;
    logic [7:0] val;
    logic [8:0] idx;
    bit         found;
    bit         lastrow;
    bit         lastpkt;
    r = '0;
    if (req == REQ_PULL) begin
      r.status = ST_NONE;
      if (ps_ready[k]) begin
        w.pos   = {1'b0, ps_rpos[k]};
        w.off   = {1'b0, ps_roff[k]};
        w.level = ps_level[k];
        w.code  = ps_code[k];
        w.len   = ps_rlen[k];
        if (w.off < {1'b0, w.len} && w.pos < {1'b0, ps_dlen[k]}) begin
          found = 1'b1;
        end else begin
          found = seek_row(k, w);
        end
        if (!found) begin
          ps_ready[k] = 1'b0;
        end else begin
          val = ps_store[k][w.pos];
          idx = w.off;
          w.off = w.off + 9'd1;
          w.pos = w.pos + 9'd1;
          lastrow = !(w.off < {1'b0, w.len} && w.pos < {1'b0, ps_dlen[k]});
          lastpkt = 1'b0;
          if (lastrow) begin
            t = w;
            lastpkt = !seek_row(k, t);
          end
          ps_rpos[k]  = w.pos[7:0];
          ps_roff[k]  = w.off[7:0];
          ps_level[k] = w.level;
          ps_code[k]  = w.code;
          ps_rlen[k]  = w.len;
          if (lastpkt) ps_ready[k] = 1'b0;
          r.status         = ST_ROW;
          r.ext_level      = w.level;
          r.row_code       = w.code;
          r.row_length     = w.len;
          r.byte_index     = idx[7:0];
          r.value_byte     = val;
          r.last_in_row    = lastrow;
          r.last_in_packet = lastpkt;
        end
      end
    end else begin
      r.status = ST_TAKEN;
      case (ps_phase[k])
        WAIT_SYNC1: begin
          if (b == SYNC_BYTE) ps_phase[k] = WAIT_SYNC2;
        end
        WAIT_SYNC2: begin
          if (b == SYNC_BYTE) begin
            ps_phase[k] = WAIT_LEN;
          end else begin
            ps_phase[k] = WAIT_SYNC1;
          end
        end
        WAIT_LEN: begin
          ps_dlen[k] = b;
          if (b > LEN_ESC) begin
            ps_phase[k] = WAIT_SYNC1;
            r.status = ST_LEN_BIG;
          end else if (b == LEN_ESC) begin
            r.status = ST_LEN_ESC;
          end else begin
            ps_rcnt[k]  = 8'h00;
            ps_sum[k]   = 8'h00;
            ps_ready[k] = 1'b0;
            ps_phase[k] = GET_PAYLOAD;
          end
        end
        GET_PAYLOAD: begin
          ps_store[k][ps_rcnt[k]] = b;
          ps_rcnt[k] = ps_rcnt[k] + 8'd1;
          ps_sum[k]  = ps_sum[k] + b;
          if (ps_rcnt[k] >= ps_dlen[k]) ps_phase[k] = GET_CHECK;
        end
        GET_CHECK: begin
          ps_phase[k] = WAIT_SYNC1;
          if (b != ~ps_sum[k]) begin
            r.status = ST_CSUM_BAD;
          end else begin
            r.status    = ST_GOOD;
            ps_ready[k] = 1'b1;
            ps_rpos[k]  = 8'h00;
            ps_level[k] = 8'h00;
            ps_code[k]  = 8'h00;
            ps_rlen[k]  = 8'h00;
            ps_roff[k]  = 8'h00;
          end
        end
        RAW_HIGH: begin
          if ((b & RAW_MASK) == RAW_HI) ps_phase[k] = RAW_LOW;
        end
        RAW_LOW: begin
          if ((b & RAW_MASK) == RAW_LO) begin
            r.status     = ST_RAW;
            r.row_code   = RAW_CODE;
            r.row_length = RAW_LEN;
            r.raw_word   = {ps_prev[k], b};
          end
          ps_phase[k] = RAW_HIGH;
        end
        default: begin
          parser_restart(k);
        end
      endcase
      ps_prev[k] = b;
    end
    return r;
  endfunction

  // Queue one transaction; drop pulls that would walk past what was ever stored.
  task automatic add_item(input logic req, input logic [7:0] b);
    job_t job;
    if (!(req == REQ_PULL && ps_ready[PLAN] && ps_dlen[PLAN] >= LEN_ESC)) begin
      job.op   = JOB_XFER;
      job.req  = req;
      job.data = b;
      stream_jobs_q.push_back(job);
      void'(parse_transaction(PLAN, req, b));
      counted++;
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    add_item(REQ_STREAM, b);
  endtask

  task automatic add_pull();
    add_item(REQ_PULL, 8'($urandom));
  endtask

  task automatic add_mode(input logic m);
    job_t job;
    job.op   = JOB_MODE;
    job.req  = REQ_STREAM;
    job.data = {7'd0, m};
    stream_jobs_q.push_back(job);
    parser_set_mode(PLAN, m);
  endtask

  task automatic add_packet();
    logic [7:0] body [$];
    logic [7:0] sum8;
    logic [7:0] csum;
    int         len;
    int         n;
    int         rl;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 169) : $urandom_range(0, 24);
    if ($urandom_range(0, 39) == 0) len = 169;
    n = (len == 0) ? 1 : len;
    while (body.size() < n) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          repeat ($urandom_range(1, 3)) body.push_back(EXT_BYTE);
        end
        2, 3, 4, 5: begin
          body.push_back(8'($urandom_range(0, 127)));
          body.push_back(8'($urandom));
        end
        default: begin
          rl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
          body.push_back(8'($urandom_range(128, 255)));
          body.push_back(8'(rl));
          repeat (rl) body.push_back(8'($urandom));
        end
      endcase
    end
    add_byte(SYNC_BYTE);
    add_byte(SYNC_BYTE);
    if ($urandom_range(0, 7) == 0) add_byte(LEN_ESC);
    add_byte(8'(len));
    sum8 = 8'h00;
    for (int i = 0; i < n; i++) begin
      add_byte(body[i]);
      sum8 = sum8 + body[i];
      if ($urandom_range(0, 29) == 0) add_pull();
    end
    csum = ~sum8;
    if ($urandom_range(0, 6) == 0) csum = csum ^ 8'($urandom_range(1, 255));
    add_byte(csum);
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n + 2) add_pull();
  endtask

  task automatic add_packet_unit();
    int len;
    case ($urandom_range(0, 9))
      7: begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
      end
      8: begin
        add_byte(SYNC_BYTE);
        add_byte(SYNC_BYTE);
        add_byte(8'($urandom_range(171, 255)));
        repeat ($urandom_range(0, 2)) add_pull();
      end
      9: begin
        // truncated packet, pulls land during reception
        len = $urandom_range(1, 20);
        add_byte(SYNC_BYTE);
        add_byte(SYNC_BYTE);
        add_byte(8'(len));
        repeat ($urandom_range(0, len - 1)) add_byte(8'($urandom));
        repeat ($urandom_range(0, 3)) add_pull();
      end
      default: add_packet();
    endcase
  endtask

  task automatic add_raw_unit();
    case ($urandom_range(0, 19))
      14, 15, 16: add_byte(8'($urandom));
      17: add_pull();
      18: begin
        add_byte(RAW_HI | 8'($urandom_range(0, 63)));
        add_byte(RAW_HI | 8'($urandom_range(0, 63)));
        add_byte(RAW_LO | 8'($urandom_range(0, 63)));
      end
      19: begin
        add_byte(RAW_HI | 8'($urandom_range(0, 63)));
        add_byte((($urandom_range(0, 1) == 0) ? 8'h00 : 8'hC0) | 8'($urandom_range(0, 63)));
      end
      default: begin
        add_byte(RAW_HI | 8'($urandom_range(0, 63)));
        add_byte(RAW_LO | 8'($urandom_range(0, 63)));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want_v, got_v);
    end
  endtask

  // Driver: present queued transactions in bursts, write the mode only when idle.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    job_t       job;
    logic       fire;
    logic       nx_valid;
    logic       nx_req;
    logic [7:0] nx_data;
    logic       nx_we;
    logic       nx_wdata;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      req_type   <= REQ_STREAM;
      data_byte  <= 8'h00;
      cfg_we     <= 1'b0;
      cfg_wdata  <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
      settle_cnt = 0;
      parser_reset(LIVE);
    end else begin
      fire = in_valid && !in_stall;
      if (fire) parser_results_q.push_back(parse_transaction(LIVE, req_type, data_byte));
      nx_valid = in_valid && !fire;
      nx_req   = req_type;
      nx_data  = data_byte;
      nx_we    = 1'b0;
      nx_wdata = cfg_wdata;
      if (!nx_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stream_jobs_q.size() != 0) begin
          job = stream_jobs_q[0];
          if (job.op == JOB_MODE) begin
            // hold until every result is back and the block has settled
            if (parser_results_q.size() == 0 && !fire && !out_valid) begin
              settle_cnt++;
            end else begin
              settle_cnt = 0;
            end
            if (settle_cnt > SETTLE_CYCLES) begin
              job = stream_jobs_q.pop_front();
              nx_we    = 1'b1;
              nx_wdata = job.data[0];
              parser_set_mode(LIVE, job.data[0]);
              settle_cnt = 0;
            end
          end else begin
            job = stream_jobs_q.pop_front();
            nx_valid = 1'b1;
            nx_req   = job.req;
            nx_data  = job.data;
            burst_left--;
            if (burst_left == 0) begin
              burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 12);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
          end
        end
      end
      in_valid  <= nx_valid;
      req_type  <= nx_req;
      data_byte <= nx_data;
      cfg_we    <= nx_we;
      cfg_wdata <= nx_wdata;
    end
  end

  // Monitor: compare each accepted result, stall on a pattern of its own.
  always @(posedge clk_i or negedge rst_ni) begin : observe_proc
    res_t want;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parser_results_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result transaction, expected none, actual status %0d",
                   $time, status);
        end else begin
          want = parser_results_q.pop_front();
          check_field("status", 16'(want.status), 16'(status));
          check_field("ext_level", 16'(want.ext_level), 16'(ext_level));
          check_field("row_code", 16'(want.row_code), 16'(row_code));
          check_field("row_length", 16'(want.row_length), 16'(row_length));
          check_field("byte_index", 16'(want.byte_index), 16'(byte_index));
          check_field("value_byte", 16'(want.value_byte), 16'(value_byte));
          check_field("last_in_row", 16'(want.last_in_row), 16'(last_in_row));
          check_field("last_in_packet", 16'(want.last_in_packet), 16'(last_in_packet));
          check_field("raw_word", want.raw_word, raw_word);
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    int phase_no;
    int phase_end;
    bit raw;
    parser_reset(PLAN);

    add_pull();                                     // nothing received yet
    add_byte(SYNC_BYTE); add_byte(SYNC_BYTE); add_byte(8'hFF);  // length too big
    add_byte(SYNC_BYTE); add_byte(SYNC_BYTE); add_byte(LEN_ESC);
    add_byte(8'h00);                                // reread as length zero
    add_byte(8'hFF); add_byte(8'h00);               // one byte still taken, good checksum
    add_pull();                                     // packet holds no value bytes
    // level byte, short row, then a long code cut off before its length byte
    add_byte(SYNC_BYTE); add_byte(SYNC_BYTE); add_byte(8'd4);
    add_byte(EXT_BYTE); add_byte(8'h02); add_byte(8'h33); add_byte(LONG_CODE_MIN);
    add_byte(8'hF5);
    add_pull(); add_pull();
    add_byte(SYNC_BYTE); add_byte(SYNC_BYTE); add_byte(8'd1);
    add_byte(8'h7F); add_byte(8'h00);               // bad checksum
    add_pull();

    phase_no = 0;
    while (counted < ITEM_TARGET) begin
      if (phase_no == 0) begin
        raw = 1'b1;
      end else if (phase_no == 1) begin
        raw = 1'b0;
      end else begin
        raw = ($urandom_range(0, 3) == 0);
      end
      add_mode(raw);
      phase_end = counted + $urandom_range(120, 260);
      while (counted < phase_end && counted < ITEM_TARGET) begin
        if (raw) begin
          add_raw_unit();
        end else begin
          add_packet_unit();
        end
      end
      phase_no++;
    end

    while (stream_jobs_q.size() != 0 || in_valid || parser_results_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("sync_length_checksum_packet_parser_core_test passed");
    end else begin
      $display("sync_length_checksum_packet_parser_core_test failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("sync_length_checksum_packet_parser_core_test failed");
    $finish;
  end

endmodule

>>> sync_length_checksum_packet_parser_core.f
hw/rtl/slcp_pkg.sv
hw/rtl/slcp_ram.sv
hw/rtl/slcp_stream.sv
hw/rtl/slcp_walker.sv
hw/rtl/slcp_outbuf.sv
hw/rtl/sync_length_checksum_packet_parser_core.sv
tb/sync_length_checksum_packet_parser_core_test.sv
